FILE: src/bums_pkg.sv
// package with shared constants and types of the merge sorter
`timescale 1ns / 1ps

package bums_pkg;

   localparam int CAPACITY   = 32;
   localparam int VALUE_BITS = 8;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
   } slot_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_EMIT
   } state_type;

endpackage

FILE: src/bums_cell.sv
// sort cell: keeps the smaller value, passes the larger right, or shifts left
`timescale 1ns / 1ps

module bums_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  bums_pkg::slot_type carry_i,
   input  bums_pkg::slot_type next_hold_i,
   output bums_pkg::slot_type carry_o,
   output bums_pkg::slot_type hold_o
);
   import bums_pkg::*;

   slot_type hold_ff;
   slot_type hold_in;
   slot_type carry_ff;
   slot_type carry_in;

   always_comb begin
      hold_in  = hold_ff;
      carry_in = '0;
      if (shift) begin
         hold_in = next_hold_i;
      end else if (carry_i.valid) begin
         if (!hold_ff.valid) begin
            hold_in = carry_i;
         end else if (carry_i.value < hold_ff.value) begin
            hold_in  = carry_i;
            carry_in = hold_ff;
         end else begin
            carry_in = carry_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.valid  <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         hold_ff  <= hold_in;
         carry_ff <= carry_in;
      end
   end

   assign carry_o = carry_ff;
   assign hold_o  = hold_ff;

endmodule

FILE: src/bottom_up_merge_sorter.sv
// top level: systolic chain of sorting cells with load, settle and emit control
//
// usage:
// - req channel (req_valid/req_ready) carries one value per transaction;
//   req_last_in marks the final value of a run and starts the sort
// - values are taken one per cycle while loading; each enters the chain
//   of CAPACITY cells and ripples right, one cell per cycle, until it
//   finds its place, so the chain is always ordered ascending
// - values beyond CAPACITY in one run are dropped and every result of
//   that run carries rsp_overflowed
// - after the last transaction the chain settles until no value still
//   ripples (any_carry low); emission then starts from cell zero
// - rsp channel (rsp_valid/rsp_ready) gives one sorted value per cycle,
//   rsp_last_out on the final one; the whole chain shifts left on each
//   taken result, and a stalled receiver simply freezes the chain
// - a run passes through the load, settle and emit phases in turn, the
//   settle phase lasting while values ripple through the cell chain; no
//   new run is taken until the last result is delivered
// - reset clears all cell valid bits, the fill count and the overflow
//   flag, and the block comes up ready to load
`timescale 1ns / 1ps

module bottom_up_merge_sorter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bums_pkg::VALUE_BITS-1:0] req_value,
   input  logic                          req_last_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bums_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   output logic                          rsp_last_out,
   output logic                          rsp_overflowed
);
   import bums_pkg::*;

   state_type            state_ff;
   state_type            state_in;
   logic [CNT_BITS-1:0]  fill_count_ff;
   logic [CNT_BITS-1:0]  fill_count_in;
   logic                 overflow_ff;
   logic                 overflow_in;

   slot_type             carry [CAPACITY+1];
   slot_type             hold  [CAPACITY+1];
   logic                 shift;
   logic                 req_take;
   logic                 rsp_take;
   logic                 full;
   logic                 any_carry;

   assign full     = (fill_count_ff == CNT_BITS'(CAPACITY));
   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign shift    = rsp_take;

   assign carry[0].valid = req_take && !full;
   assign carry[0].value = req_value;
   assign hold[CAPACITY] = '0;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         bums_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift),
            .carry_i     (carry[g]),
            .next_hold_i (hold[g+1]),
            .carry_o     (carry[g+1]),
            .hold_o      (hold[g])
         );
      end
   endgenerate

   always_comb begin
      any_carry = 1'b0;
      for (int i = 1; i <= CAPACITY; i++) begin
         any_carry = any_carry | carry[i].valid;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req_last_in) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            if (!any_carry) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take && (fill_count_ff == CNT_BITS'(1))) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      case (state_ff)
         ST_LOAD:   req_ready = 1'b1;
         ST_SETTLE: req_ready = 1'b0;
         ST_EMIT:   rsp_valid = 1'b1;
         default:   req_ready = 1'b0;
      endcase
      rsp_sorted_value = hold[0].value;
      rsp_last_out     = (fill_count_ff == CNT_BITS'(1));
      rsp_overflowed   = overflow_ff;
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      if (req_take) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            fill_count_in = fill_count_ff + CNT_BITS'(1);
         end
      end
      if (rsp_take) begin
         fill_count_in = fill_count_ff - CNT_BITS'(1);
         if (fill_count_ff == CNT_BITS'(1)) begin
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
      end
   end

`ifndef SYNTH
   a_emit_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> hold[0].valid)
      else $error("emitting from an empty cell");

   a_emit_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !any_carry)
      else $error("emitting while values still ripple");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count above capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (full || (state_ff == ST_EMIT)))
      else $error("overflow flagged without a full store");

   a_run_done_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_out) |=> (!hold[0].valid && (fill_count_ff == '0)))
      else $error("chain not empty after final result");
`endif

endmodule

FILE: sim/merge_sort_checker.sv
// checker: predicts each sorted run from the input transactions and compares the results
`timescale 1ns / 1ps

module merge_sort_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [bums_pkg::VALUE_BITS-1:0] req_value,
   input  logic                           req_last_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [bums_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   input  logic                           rsp_last_out,
   input  logic                           rsp_overflowed,
   output int                             error_count,
   output int                             pending,
   output int                             results_checked
);

   typedef struct packed {
      logic [bums_pkg::VALUE_BITS-1:0] value;
      logic                            last_out;
      logic                            overflowed;
   } sorted_entry_type;

   sorted_entry_type expected_sorted[$];

   logic [bums_pkg::VALUE_BITS-1:0] run_values [0:bums_pkg::CAPACITY-1];
   int   run_fill;
   logic run_overflow;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic take_value(input logic [bums_pkg::VALUE_BITS-1:0] v);
      if (run_fill < bums_pkg::CAPACITY) begin
         run_values[run_fill] = v;
         run_fill++;
      end else begin
         run_overflow = 1'b1;
      end
   endtask

   task automatic predict_sorted_run();
      logic [bums_pkg::VALUE_BITS-1:0] key;
      sorted_entry_type entry;
      int i;
      int j;
      for (i = 1; i < run_fill; i++) begin
         key = run_values[i];
         j = i - 1;
         while (j >= 0 && run_values[j] > key) begin
            run_values[j+1] = run_values[j];
            j--;
         end
         run_values[j+1] = key;
      end
      for (i = 0; i < run_fill; i++) begin
         entry.value      = run_values[i];
         entry.last_out   = (i == run_fill - 1);
         entry.overflowed = run_overflow;
         expected_sorted.push_back(entry);
      end
      run_fill     = 0;
      run_overflow = 1'b0;
   endtask

   task automatic check_result();
      sorted_entry_type want;
      if (expected_sorted.size() == 0) begin
         report_mismatch("unexpected result transaction", rsp_sorted_value, -1);
      end else begin
         want = expected_sorted.pop_front();
         results_checked++;
         if (rsp_sorted_value !== want.value)
            report_mismatch("sorted_value", rsp_sorted_value, want.value);
         if (rsp_last_out !== want.last_out)
            report_mismatch("last_out", rsp_last_out, want.last_out);
         if (rsp_overflowed !== want.overflowed)
            report_mismatch("overflowed", rsp_overflowed, want.overflowed);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_fill     = 0;
         run_overflow = 1'b0;
         expected_sorted.delete();
      end else begin
         if (req_valid && req_ready) begin
            take_value(req_value);
            if (req_last_in)
               predict_sorted_run();
         end
         if (rsp_valid && rsp_ready)
            check_result();
      end
      pending = expected_sorted.size();
   end

endmodule

FILE: sim/bottom_up_merge_sorter_tb.sv
// testbench top: stimulus, idling on both channels and the final verdict
`timescale 1ns / 1ps

module bottom_up_merge_sorter_tb;

   localparam int RANDOM_ITEMS = 210;
   localparam int LONG_HOLD    = 300;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [bums_pkg::VALUE_BITS-1:0] req_value;
   logic                           req_last_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [bums_pkg::VALUE_BITS-1:0] rsp_sorted_value;
   logic                           rsp_last_out;
   logic                           rsp_overflowed;

   int error_count;
   int pending;
   int results_checked;

   int   items_sent;
   int   runs_sent;
   int   overflow_runs;
   int   directed_items;
   bit   idle_on;
   bit   start_long_hold;
   bit   long_hold_done;
   logic [bums_pkg::VALUE_BITS-1:0] run_buf [0:63];

   bottom_up_merge_sorter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed)
   );

   merge_sort_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflowed   (rsp_overflowed),
      .error_count      (error_count),
      .pending          (pending),
      .results_checked  (results_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("timeout with %0d results still pending", pending);
      $display("Test completed with failures");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [bums_pkg::VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return bums_pkg::VALUE_BITS'($urandom_range(0, 3));
      else if (r < 40)
         return (r < 35) ? '0 : '1;
      else
         return bums_pkg::VALUE_BITS'($urandom_range(0, 255));
   endfunction

   task automatic send_item(input logic [bums_pkg::VALUE_BITS-1:0] v, input logic last);
      int gap;
      gap = pick_idle();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_last_in <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_run(input int len);
      int k;
      for (k = 0; k < len; k++)
         send_item(run_buf[k], k == len - 1);
      runs_sent++;
      if (len > bums_pkg::CAPACITY)
         overflow_runs++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // receiver side
   initial begin
      int hold;
      rsp_ready = 1'b0;
      hold = 0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (start_long_hold && !long_hold_done) begin
            hold = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_idle();
         end
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int run_idx;
      int len;
      int r;
      int k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_last_in     = 1'b0;
      idle_on         = 1'b0;
      start_long_hold = 1'b0;
      items_sent      = 0;
      runs_sent       = 0;
      overflow_runs   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single values at both extremes, then both extremes in one run
      run_buf[0] = 8'd0;
      send_run(1);
      run_buf[0] = 8'd255;
      send_run(1);
      idle_on = 1'b1;
      run_buf[0] = 8'd255;
      run_buf[1] = 8'd0;
      send_run(2);
      // equal values, then a mixed run with a repeated value
      run_buf[0] = 8'd7;
      run_buf[1] = 8'd7;
      run_buf[2] = 8'd7;
      send_run(3);
      run_buf[0] = 8'd128;
      run_buf[1] = 8'd1;
      run_buf[2] = 8'd254;
      run_buf[3] = 8'd1;
      run_buf[4] = 8'd2;
      send_run(5);
      // descending run
      for (k = 0; k < 8; k++)
         run_buf[k] = 8'd255 - 8'(k * 36);
      send_run(8);
      directed_items = items_sent;
      wait_drained();

      run_idx = 0;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         case (run_idx)
            2:       len = bums_pkg::CAPACITY;
            3:       len = 12;
            4:       len = 6;
            5:       len = bums_pkg::CAPACITY + 5;
            default: begin
               if (r < 80)
                  len = $urandom_range(1, 10);
               else if (r < 92)
                  len = $urandom_range(11, bums_pkg::CAPACITY - 1);
               else
                  len = $urandom_range(bums_pkg::CAPACITY, bums_pkg::CAPACITY + 8);
            end
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         // receiver stalls long while the sender keeps offering
         if (run_idx == 3)
            start_long_hold = 1'b1;
         if (run_idx == 8)
            wait_drained();
         for (k = 0; k < len; k++)
            run_buf[k] = pick_value();
         send_run(len);
         run_idx++;
      end

      wait_drained();
      repeat (50) @(posedge clock);
      $display("summary: %0d runs, %0d values sent, %0d runs past capacity",
               runs_sent, items_sent, overflow_runs);
      $display("summary: %0d sorted results checked, %0d mismatches",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
src/bums_pkg.sv
src/bums_cell.sv
src/bottom_up_merge_sorter.sv
sim/merge_sort_checker.sv
sim/bottom_up_merge_sorter_tb.sv
